// File: hw/rtl/sod_pkg.sv
// shared types, constants and register codes for the sparkle overlay
`default_nettype none

package sod_pkg;

	localparam int PIXELS_DEF = 64;
	localparam int COLOUR_W   = 8;
	localparam int INDEX_W    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 3'd0,
		REG_RED    = 3'd1,
		REG_GREEN  = 3'd2,
		REG_BLUE   = 3'd3,
		REG_DECAY  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic                enable;
		logic                clear;
		rgb_t                colour;
		logic [COLOUR_W-1:0] decay;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/sod_if.sv
// handshake interfaces for pixel words, result words and register writes
`default_nettype none

interface sod_pix_if import sod_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] pixel_red;
	logic [COLOUR_W-1:0] pixel_green;
	logic [COLOUR_W-1:0] pixel_blue;
	logic [INDEX_W-1:0]  pixel_index;
	logic                ignite;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_index, ignite,
		input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_index, ignite,
		output ready);
endinterface

interface sod_out_if import sod_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] out_red;
	logic [COLOUR_W-1:0] out_green;
	logic [COLOUR_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface sod_cfg_if import sod_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sod_cfg_regs.sv
// configuration registers and store clear on an enable change
`default_nettype none

module sod_cfg_regs import sod_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sod_cfg_if.sink   cfg,
	output cfg_t      cfg_state
);

	logic                enable_q;
	rgb_t                colour_q;
	logic [COLOUR_W-1:0] decay_q;
	logic                wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			colour_q <= '{red: 8'hff, green: 8'hff, blue: 8'hff};
			decay_q  <= COLOUR_W'(3);
		end else if (wr) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ENABLE: enable_q       <= cfg.data[0];
				REG_RED:    colour_q.red   <= cfg.data[COLOUR_W-1:0];
				REG_GREEN:  colour_q.green <= cfg.data[COLOUR_W-1:0];
				REG_BLUE:   colour_q.blue  <= cfg.data[COLOUR_W-1:0];
				REG_DECAY:  decay_q        <= cfg.data[COLOUR_W-1:0];
				default:    ;
			endcase
		end
	end

	// clear lands on the same edge as the write that flips enable
	always_comb begin
		cfg_state.enable = enable_q;
		cfg_state.colour = colour_q;
		cfg_state.decay  = decay_q;
		cfg_state.clear  = wr && (cfg_reg_t'(cfg.index) == REG_ENABLE)
			&& (cfg.data[0] != enable_q);
	end

endmodule

`default_nettype wire

// File: hw/rtl/sod_store.sv
// sparkle store: per-pixel colour memory with valid bits and write forwarding
`default_nettype none

module sod_store import sod_pkg::*; #(
	parameter int PIXELS = PIXELS_DEF,
	localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  rgb_t               wr_data,
	output rgb_t               rd_data
);

	rgb_t              mem [PIXELS];
	rgb_t              mem_q;
	rgb_t              fwd_q;
	logic              vld_q;
	logic              hit_q;
	logic [PIXELS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			mem_q <= mem[rd_addr];
		if (rd_en)
			fwd_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en) begin
				vld_q <= valid_q[rd_addr];
				hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// an entry never written since the last clear reads as black
	assign rd_data = hit_q ? fwd_q : (vld_q ? mem_q : '0);

endmodule

`default_nettype wire

// File: hw/rtl/sod_merge.sv
// per-channel maximum merge and next sparkle value
`default_nettype none

module sod_merge import sod_pkg::*; (
	input  wire logic          active,
	input  wire logic          ignite,
	input  rgb_t               pixel,
	input  rgb_t               stored,
	input  rgb_t               colour,
	input  wire logic [COLOUR_W-1:0] decay,
	output rgb_t               merged,
	output rgb_t               next
);

	function automatic logic [COLOUR_W-1:0] max8(input logic [COLOUR_W-1:0] a,
		input logic [COLOUR_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [COLOUR_W-1:0] fade(input logic [COLOUR_W-1:0] s,
		input logic [COLOUR_W-1:0] d);
		return (s > d) ? s - d : '0;
	endfunction

	always_comb begin
		if (active) begin
			merged.red   = max8(pixel.red, stored.red);
			merged.green = max8(pixel.green, stored.green);
			merged.blue  = max8(pixel.blue, stored.blue);
		end else begin
			merged = pixel;
		end
		if (ignite) begin
			next = colour;
		end else begin
			next.red   = fade(stored.red, decay);
			next.green = fade(stored.green, decay);
			next.blue  = fade(stored.blue, decay);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sparkle_overlay_decay.sv
// top level of the sparkle overlay with decaying per-pixel sparkle store
//
//   channel  modport  word                                          handshake
//   pixel    sink     pixel_red/green/blue, pixel_index, ignite     valid/ready
//   result   source   out_red/green/blue                            valid/ready
//   cfg      sink     index (register), data                        valid/ready, ready tied high
//
// one pixel word a cycle sustained while the result side keeps taking words; a pixel
//   passes the merge stage register and then the result register, which drives result valid;
//   the store's registered read port feeds the merge stage
// reset clears the valid bits of the store at once, so no sweep after reset
// an enable change clears the valid bits in the cycle of the write
// a stalled result holds the merge stage; pixel ready drops only while both stages are full
`default_nettype none

module sparkle_overlay_decay import sod_pkg::*; #(
	parameter int PIXELS = PIXELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sod_pix_if.sink   pixel,
	sod_out_if.source result,
	sod_cfg_if.sink   cfg
);

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int EW = (AW > INDEX_W) ? AW : INDEX_W;

	cfg_t cfg_state;

	// input side
	logic          acc_in;
	logic          in_range;
	logic [EW-1:0] idx_ext;
	logic [AW-1:0] rd_addr;

	// merge stage
	logic          valid_s1;
	logic          fire_s1;
	rgb_t          pix_s1;
	logic [AW-1:0] addr_s1;
	logic          live_s1;
	logic          ignite_s1;
	logic          active_s1;
	rgb_t          stored_s1;
	rgb_t          merged_s1;
	rgb_t          next_s1;

	// result register
	logic          valid_s2;
	rgb_t          rgb_s2;

	sod_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_state (cfg_state)
	);

	// indexes past the store merge with black and leave the store alone
	assign idx_ext  = EW'(pixel.pixel_index);
	assign in_range = 32'(pixel.pixel_index) < 32'(PIXELS);
	assign rd_addr  = idx_ext[AW-1:0];

	assign fire_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign pixel.ready = !valid_s1 || fire_s1;
	assign acc_in      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			pix_s1    <= '{red: pixel.pixel_red, green: pixel.pixel_green,
				blue: pixel.pixel_blue};
			addr_s1   <= rd_addr;
			live_s1   <= in_range;
			ignite_s1 <= pixel.ignite;
		end
	end

	assign active_s1 = live_s1 && cfg_state.enable;

	// read on accept, write back as the word leaves the merge stage;
	// a pixel right behind on the same index picks up the write by forwarding
	sod_store #(
		.PIXELS (PIXELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_state.clear),
		.rd_en   (acc_in && in_range),
		.rd_addr (rd_addr),
		.wr_en   (fire_s1 && active_s1),
		.wr_addr (addr_s1),
		.wr_data (next_s1),
		.rd_data (stored_s1)
	);

	sod_merge u_merge (
		.active (active_s1),
		.ignite (ignite_s1),
		.pixel  (pix_s1),
		.stored (stored_s1),
		.colour (cfg_state.colour),
		.decay  (cfg_state.decay),
		.merged (merged_s1),
		.next   (next_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1)
			rgb_s2 <= merged_s1;
	end

	assign result.valid     = valid_s2;
	assign result.out_red   = rgb_s2.red;
	assign result.out_green = rgb_s2.green;
	assign result.out_blue  = rgb_s2.blue;

endmodule

`default_nettype wire

// File: hw/rtl/sod_checker.sv
// port-level checks on the sparkle overlay, bound to the top level
`default_nettype none

module sod_checker import sod_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [COLOUR_W-1:0] out_red,
	input wire logic [COLOUR_W-1:0] out_green,
	input wire logic [COLOUR_W-1:0] out_blue
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("result word changed while stalled");

	// pixel side backs up only when both stages hold a word and the result is stalled
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pixel ready low without a stalled result");

	// a result after an empty output comes from an accepted pixel that went straight through the merge stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared with no pixel accepted");

endmodule

bind sparkle_overlay_decay sod_checker u_sod_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_red   (result.out_red),
	.out_green (result.out_green),
	.out_blue  (result.out_blue)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the sparkle overlay: directed table, then paced random phases
`timescale 1ns / 1ps

module tb_top;
	import sod_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 130;
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off while the pixel side keeps offering
	localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all before giving up
	localparam int TAIL_CYCLES = 4;     // tail after the last phase so a stray extra result word is still caught
	localparam int SHOWN_FAULTS = 10;
	localparam int PRESSURE_PHASE = 3;

	// register indexes past the end of the map, written to prove they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {PACE_FULL, PACE_SHORT, PACE_MIXED} pace_t;

	typedef struct packed {
		rgb_t                colour;
		logic [INDEX_W-1:0]  index;
		logic                ignite;
	} pixel_word_t;

	// one line of the directed table: either a register write or a pixel word
	typedef struct {
		bit                    reg_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		pixel_word_t           word;
		bit                    typed;
		rgb_t                  want;
	} step_row_t;

	logic clk;
	logic arst_n;

	sod_pix_if pix_bus ();
	sod_out_if res_bus ();
	sod_cfg_if cfg_bus ();

	sparkle_overlay_decay #(.PIXELS(PIXELS_DEF)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// local copy of the overlay state, kept in step with accepted words
	rgb_t                sparkle_mem [PIXELS_DEF];
	logic                overlay_on;
	logic                last_on;
	rgb_t                ignite_colour;
	logic [COLOUR_W-1:0] fade_step;

	rgb_t  merged_q [$];   // merged colours still owed by the block, oldest first
	int    fail_count;
	bit    hold_off;       // raised by the stimulus, served and cleared by the receiver
	pace_t send_pace;
	pace_t take_pace;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [COLOUR_W-1:0] brighter(logic [COLOUR_W-1:0] a,
			logic [COLOUR_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// one visit's worth of decay, stopping at zero
	function automatic logic [COLOUR_W-1:0] faded(logic [COLOUR_W-1:0] s);
		return (s > fade_step) ? s - fade_step : '0;
	endfunction

	// merged colour for one pixel word; ages or reloads that pixel's sparkle
	function automatic rgb_t blend_and_age(pixel_word_t w);
		rgb_t held;
		rgb_t merged;
		// every 6-bit index lies inside the 64-entry store, so no out-of-range path
		if (!overlay_on)
			return w.colour;
		held = sparkle_mem[w.index];
		merged = {brighter(w.colour.red, held.red), brighter(w.colour.green, held.green),
			brighter(w.colour.blue, held.blue)};
		if (w.ignite)
			sparkle_mem[w.index] = ignite_colour;
		else
			sparkle_mem[w.index] = {faded(held.red), faded(held.green), faded(held.blue)};
		return merged;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ENABLE: begin
				// only a real change of the enable wipes the store
				if (data[0] != last_on) begin
					foreach (sparkle_mem[i])
						sparkle_mem[i] = '0;
					last_on = data[0];
				end
				overlay_on = data[0];
			end
			REG_RED:   ignite_colour.red   = data;
			REG_GREEN: ignite_colour.green = data;
			REG_BLUE:  ignite_colour.blue  = data;
			REG_DECAY: fade_step           = data;
			default: ;  // unmapped index, nothing changes
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int pick_gap(pace_t p);
		int roll;
		roll = $urandom_range(0, 99);
		case (p)
			PACE_FULL:  return 0;
			PACE_SHORT: return (roll < 50) ? 0 : $urandom_range(1, 3);
			default: begin
				// mostly short gaps, now and then a long one
				if (roll < 40)
					return 0;
				else if (roll < 88)
					return $urandom_range(1, 3);
				else
					return $urandom_range(8, 40);
			end
		endcase
	endfunction

	// colour level with the extremes drawn more often than chance would give
	function automatic logic [COLOUR_W-1:0] rand_level();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		return COLOUR_W'($urandom_range(0, 255));
	endfunction

	// half the words land near a hot spot so sparkles get revisited back to back
	function automatic pixel_word_t random_word(logic [INDEX_W-1:0] hot_base);
		pixel_word_t w;
		w.colour = {rand_level(), rand_level(), rand_level()};
		if ($urandom_range(0, 1) == 0)
			w.index = hot_base + INDEX_W'($urandom_range(0, 3));
		else
			w.index = INDEX_W'($urandom_range(0, PIXELS_DEF - 1));
		w.ignite = ($urandom_range(0, 5) == 0);
		return w;
	endfunction

	function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		step_row_t r;
		r.reg_write = 1'b1;
		r.reg_index = idx;
		r.reg_data  = data;
		r.word      = '0;
		r.typed     = 1'b0;
		r.want      = '0;
		return r;
	endfunction

	function automatic step_row_t pix_row(rgb_t c, logic [INDEX_W-1:0] idx, logic ign);
		step_row_t r;
		r.reg_write = 1'b0;
		r.reg_index = REG_ENABLE;
		r.reg_data  = '0;
		r.word      = {c, idx, ign};
		r.typed     = 1'b0;
		r.want      = '0;
		return r;
	endfunction

	// pixel word whose merged colour is obvious and written out by hand
	function automatic step_row_t chk_row(rgb_t c, logic [INDEX_W-1:0] idx, logic ign,
			rgb_t want);
		step_row_t r;
		r = pix_row(c, idx, ign);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	// offer one pixel word; valid stays up afterwards so a zero gap means back to back
	task automatic send_pixel(input pixel_word_t w, input bit typed, input rgb_t want);
		int   gap;
		rgb_t model;
		gap = pick_gap(send_pace);
		if (gap > 0) begin
			pix_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_bus.valid       <= 1'b1;
		pix_bus.pixel_red   <= w.colour.red;
		pix_bus.pixel_green <= w.colour.green;
		pix_bus.pixel_blue  <= w.colour.blue;
		pix_bus.pixel_index <= w.index;
		pix_bus.ignite      <= w.ignite;
		@(posedge clk);
		while (!pix_bus.ready)
			@(posedge clk);
		// the model still runs on hand-checked rows so its state stays in step
		model = blend_and_age(w);
		merged_q.push_back(typed ? want : model);
	endtask

	// stop offering pixels and let every owed result word come out
	task automatic quiesce();
		pix_bus.valid <= 1'b0;
		@(posedge clk);
		while (merged_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		apply_reg_write(idx, data);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- result side

	// receiver: random stalls, plus the long hold-off when asked for
	initial begin
		int stall;
		res_bus.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off) begin
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				stall = pick_gap(take_pace);
				if (stall > 0) begin
					res_bus.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				res_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	rgb_t owed;
	rgb_t seen;

	// every accepted result word is matched against the oldest owed colour
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready) begin
			seen = {res_bus.out_red, res_bus.out_green, res_bus.out_blue};
			if (merged_q.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_FAULTS)
					$display("%0t: result word %02h %02h %02h with nothing owed",
						$realtime, seen.red, seen.green, seen.blue);
			end else begin
				owed = merged_q.pop_front();
				if (seen.red !== owed.red || seen.green !== owed.green
						|| seen.blue !== owed.blue) begin
					fail_count++;
					if (fail_count <= SHOWN_FAULTS)
						$display("%0t: colour mismatch, expected %02h %02h %02h, got %02h %02h %02h",
							$realtime, owed.red, owed.green, owed.blue,
							seen.red, seen.green, seen.blue);
				end
			end
		end
	end

	// watchdog: too long without any handshake on any channel means a hang
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		step_row_t           steps [$];
		int                  phase;
		int                  k;
		logic                en;
		logic [CFG_DATA_W-1:0] en_data;
		rgb_t                c;
		logic [COLOUR_W-1:0] d;
		logic [INDEX_W-1:0]  hot_base;

		// everything known from time zero, reset held low
		arst_n              = 1'b0;
		pix_bus.valid       = 1'b0;
		pix_bus.pixel_red   = '0;
		pix_bus.pixel_green = '0;
		pix_bus.pixel_blue  = '0;
		pix_bus.pixel_index = '0;
		pix_bus.ignite      = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_ENABLE;
		cfg_bus.data        = '0;
		fail_count          = 0;
		hold_off            = 1'b0;
		send_pace           = PACE_SHORT;
		take_pace           = PACE_MIXED;

		// model state as it comes out of reset
		foreach (sparkle_mem[i])
			sparkle_mem[i] = '0;
		overlay_on    = 1'b0;
		last_on       = 1'b0;
		ignite_colour = 24'hff_ff_ff;
		fade_step     = 8'd3;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		// overlay off after reset: colour passes straight through, ignite is ignored
		steps.push_back(chk_row({8'h12, 8'h34, 8'h56}, 6'd5, 1'b1, {8'h12, 8'h34, 8'h56}));
		steps.push_back(chk_row({8'hff, 8'hff, 8'hff}, 6'd63, 1'b0, {8'hff, 8'hff, 8'hff}));
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd0, 1'b0, {8'h00, 8'h00, 8'h00}));
		steps.push_back(reg_row(REG_ENABLE, 8'h01));
		// the ignite seen while off left nothing behind
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd5, 1'b0, {8'h00, 8'h00, 8'h00}));
		// ignite with the reset colour and decay of three, then watch it fade
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd0, 1'b1, {8'h00, 8'h00, 8'h00}));
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd0, 1'b0, {8'hff, 8'hff, 8'hff}));
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd0, 1'b0, {8'hfc, 8'hfc, 8'hfc}));
		steps.push_back(pix_row({8'hff, 8'h00, 8'h80}, 6'd0, 1'b0));
		// enable rewritten with the same value must not clear the store
		steps.push_back(reg_row(REG_ENABLE, 8'h01));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd0, 1'b0));
		// sparkle colour at both extremes and the largest decay
		steps.push_back(reg_row(REG_RED, 8'h00));
		steps.push_back(reg_row(REG_GREEN, 8'h80));
		steps.push_back(reg_row(REG_BLUE, 8'hff));
		steps.push_back(reg_row(REG_DECAY, 8'hff));
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd63, 1'b1, {8'h00, 8'h00, 8'h00}));
		steps.push_back(chk_row({8'h10, 8'h10, 8'h10}, 6'd63, 1'b0, {8'h10, 8'h80, 8'hff}));
		// a decay at least as big as every channel drops the sparkle to zero in one visit
		steps.push_back(chk_row({8'h01, 8'h02, 8'h03}, 6'd63, 1'b0, {8'h01, 8'h02, 8'h03}));
		// zero decay: a sparkle stays put
		steps.push_back(reg_row(REG_DECAY, 8'h00));
		steps.push_back(pix_row({8'h20, 8'h20, 8'h20}, 6'd42, 1'b1));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd42, 1'b0));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd42, 1'b0));
		// writes to unmapped indexes change nothing
		steps.push_back(reg_row(REG_SPARE_HI, 8'haa));
		steps.push_back(reg_row(REG_SPARE_LO, 8'h00));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd42, 1'b0));
		// only bit zero of the data counts: this turns the overlay off and clears
		steps.push_back(reg_row(REG_ENABLE, 8'hfe));
		steps.push_back(chk_row({8'h11, 8'h22, 8'h33}, 6'd42, 1'b0, {8'h11, 8'h22, 8'h33}));
		// back on: cleared again, the old sparkle is gone
		steps.push_back(reg_row(REG_ENABLE, 8'h01));
		steps.push_back(chk_row({8'h00, 8'h00, 8'h00}, 6'd42, 1'b0, {8'h00, 8'h00, 8'h00}));
		steps.push_back(reg_row(REG_RED, 8'hff));
		steps.push_back(reg_row(REG_GREEN, 8'hff));
		steps.push_back(reg_row(REG_BLUE, 8'hff));
		steps.push_back(reg_row(REG_DECAY, 8'h03));
		// same pixel revisited in a row, with a neighbour in between
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd7, 1'b1));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd7, 1'b0));
		steps.push_back(pix_row({8'h00, 8'h00, 8'h00}, 6'd7, 1'b0));
		steps.push_back(pix_row({8'haa, 8'h55, 8'haa}, 6'd6, 1'b0));
		steps.push_back(pix_row({8'h55, 8'haa, 8'h55}, 6'd7, 1'b0));

		foreach (steps[i]) begin
			if (steps[i].reg_write) begin
				quiesce();
				write_reg(steps[i].reg_index, steps[i].reg_data);
			end else begin
				send_pixel(steps[i].word, steps[i].typed, steps[i].want);
			end
		end
		quiesce();

		// random phases, each under its own register setting and pacing
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					// full rate both ways, zero decay
					en = 1'b1;
					c  = 24'hff_ff_ff;
					d  = 8'h00;
					send_pace = PACE_FULL;
					take_pace = PACE_FULL;
				end
				1: begin
					en = 1'b1;
					c  = 24'h00_00_00;
					d  = 8'hff;
					send_pace = PACE_MIXED;
					take_pace = PACE_MIXED;
				end
				2: begin
					// overlay off for a whole phase
					en = 1'b0;
					c  = {rand_level(), rand_level(), rand_level()};
					d  = rand_level();
					send_pace = PACE_SHORT;
					take_pace = PACE_SHORT;
				end
				PRESSURE_PHASE: begin
					en = 1'b1;
					c  = {rand_level(), rand_level(), rand_level()};
					d  = COLOUR_W'($urandom_range(1, 12));
					send_pace = PACE_FULL;
					take_pace = PACE_SHORT;
				end
				default: begin
					en = ($urandom_range(0, 4) != 0);
					c  = {rand_level(), rand_level(), rand_level()};
					// small decays keep sparkles alive across many revisits
					d  = ($urandom_range(0, 2) == 0) ? rand_level()
						: COLOUR_W'($urandom_range(1, 12));
					send_pace = pace_t'($urandom_range(PACE_FULL, PACE_MIXED));
					take_pace = pace_t'($urandom_range(PACE_FULL, PACE_MIXED));
				end
			endcase
			write_reg(REG_RED, c.red);
			write_reg(REG_GREEN, c.green);
			write_reg(REG_BLUE, c.blue);
			write_reg(REG_DECAY, d);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					CFG_DATA_W'($urandom_range(0, 255)));
			en_data    = CFG_DATA_W'($urandom_range(0, 255));
			en_data[0] = en;
			write_reg(REG_ENABLE, en_data);

			hot_base = INDEX_W'($urandom_range(0, PIXELS_DEF - 1));
			// receiver sits on its hands while pixels keep coming, so the block backs up
			if (phase == PRESSURE_PHASE)
				hold_off = 1'b1;
			for (k = 0; k < PHASE_WORDS; k++)
				send_pixel(random_word(hot_base), 1'b0, '0);
			quiesce();
		end

		// a few more cycles so a stray extra word would still be caught
		repeat (TAIL_CYCLES) @(posedge clk);
		if (merged_q.size() != 0) begin
			$display("%0d result words never arrived", merged_q.size());
			fail_count += merged_q.size();
		end
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
